// ----- src/fcb_pkg.sv -----
// Shared constants, register indexes and types of the freezer cartridge bank logic.
// Used by every other file of the block; depends on nothing.
package fcb_pkg;

	localparam int MAX_BANKS  = 16;
	localparam int BANK_BYTES = 16384;
	localparam int BANK_W     = $clog2(MAX_BANKS);
	localparam int OFF_W      = $clog2(BANK_BYTES);
	localparam int IMG_W      = BANK_W + OFF_W;
	localparam int IMG_DEPTH  = MAX_BANKS * BANK_BYTES;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 20;

	localparam logic [CFG_IDX_W-1:0] CFG_BANK_COUNT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RESET_HOLD  = 2'd2;

	localparam logic [4:0]  BANK_COUNT_RST = 5'd4;
	localparam logic [19:0] DEBOUNCE_RST   = 20'd500000;
	localparam logic [7:0]  HOLD_MIN_RST   = 8'd30;

	localparam logic [7:0] CTRL_REG_LOW = 8'hFF;
	localparam logic [4:0] IO1_PAGE     = 5'h1E;
	localparam logic [4:0] IO2_PAGE     = 5'h1F;
	localparam logic [7:0] COUNT_SAT    = 8'hFF;
	localparam logic [7:0] FREEZE_RUN   = 8'd3;

	typedef struct packed {
		logic        req_type;
		logic [17:0] rom_index;
		logic [12:0] bus_addr;
		logic        roml_sel;
		logic        romh_sel;
		logic        io1_sel;
		logic        io2_sel;
		logic        cpu_write;
		logic        vic_access;
		logic [7:0]  data_in;
		logic        freeze_button;
		logic        reset_low;
	} in_item_t;

	typedef struct packed {
		logic        drive_data;
		logic [7:0]  data_out;
		logic        exrom_ctl;
		logic        game_ctl;
		logic        nmi_ctl;
		logic        cart_active;
		logic [3:0]  bank_now;
	} out_item_t;

	typedef struct packed {
		logic [4:0]  bank_count;
		logic [19:0] debounce_cycles;
		logic [7:0]  reset_hold_min;
	} cfg_t;

	typedef struct packed {
		logic              exrom;
		logic              game;
		logic              nmi;
		logic              active;
		logic [BANK_W-1:0] bank;
	} ctl_view_t;

	typedef struct packed {
		logic             we;
		logic [IMG_W-1:0] waddr;
		logic [7:0]       wdata;
		logic             re;
		logic [IMG_W-1:0] raddr;
	} rom_port_t;

endpackage

// ----- src/fcb_in_if.sv -----
// Request channel of the bank logic: valid, ready and one input item.
// Depends on fcb_pkg for the payload type.
interface fcb_in_if import fcb_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- src/fcb_out_if.sv -----
// Result channel of the bank logic: valid, ready and one result item.
// Depends on fcb_pkg for the payload type.
interface fcb_out_if import fcb_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- src/fcb_cfg.sv -----
// Configuration registers: bank count, debounce length and reset hold threshold.
// Depends on fcb_pkg.
module fcb_cfg import fcb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  we,
	input  logic [CFG_IDX_W-1:0]  index,
	input  logic [CFG_DATA_W-1:0] wdata,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bank_count      <= BANK_COUNT_RST;
			cfg_q.debounce_cycles <= DEBOUNCE_RST;
			cfg_q.reset_hold_min  <= HOLD_MIN_RST;
		end else if (we) begin
			unique case (index)
				CFG_BANK_COUNT: cfg_q.bank_count      <= wdata[4:0];
				CFG_DEBOUNCE:   cfg_q.debounce_cycles <= wdata[19:0];
				CFG_RESET_HOLD: cfg_q.reset_hold_min  <= wdata[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- src/fcb_rom.sv -----
// Interleaved ROM image store: one write port and one registered read port.
// Depends on fcb_pkg for the image size and the port struct.
module fcb_rom import fcb_pkg::*; (
	input  logic      clk,
	input  rom_port_t rom,
	output logic [7:0] rd_data_s2
);

	logic [7:0] mem [IMG_DEPTH];

	always_ff @(posedge clk) begin
		if (rom.we) begin
			mem[rom.waddr] <= rom.wdata;
		end
		if (rom.re) begin
			rd_data_s2 <= mem[rom.raddr];
		end
	end

endmodule

// ----- src/fcb_ctrl.sv -----
// Cartridge control state: bank, control lines, freeze and long-reset tracking.
// Decodes one request a cycle while enabled and drives the ROM port; depends on fcb_pkg.
module fcb_ctrl import fcb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  in_item_t  item,
	input  cfg_t      cfg,
	output rom_port_t rom,
	output logic      drive,
	output ctl_view_t view
);

	logic              active_q, active_n;
	logic [BANK_W-1:0] bank_q, bank_n;
	logic [2:0]        line_q, line_n;
	logic [7:0]        wrun_q, wrun_n;
	logic [19:0]       deb_q, deb_n;
	logic              frz_q, frz_n;
	logic [7:0]        hold_q, hold_n;
	logic [1:0]        rflags_q, rflags_n;
	logic [OFF_W-1:0]  off;
	logic [BANK_W-1:0] mask;

	assign mask = BANK_W'(cfg.bank_count - 5'd1) & BANK_W'(MAX_BANKS - 1);

	always_comb begin
		active_n = active_q;
		bank_n   = bank_q;
		line_n   = line_q;
		wrun_n   = wrun_q;
		deb_n    = deb_q;
		frz_n    = frz_q;
		hold_n   = hold_q;
		rflags_n = rflags_q;
		drive    = 1'b0;
		off      = '0;
		if (item.req_type) begin
			drive = 1'b0;
		end else if (item.vic_access) begin
			if (item.romh_sel) begin
				drive = 1'b1;
				off   = {item.bus_addr, 1'b1};
			end
		end else begin
			if (item.reset_low) begin
				if (hold_q != COUNT_SAT) begin
					hold_n = hold_q + 8'd1;
				end
				rflags_n = 2'b01;
			end else begin
				rflags_n = {rflags_q[0] | rflags_q[1], 1'b0};
			end
			// A long reset that has been released restarts the block from its reset state.
			if (hold_n > cfg.reset_hold_min && rflags_n[1]) begin
				active_n = 1'b1;
				bank_n   = '0;
				line_n   = '0;
				wrun_n   = '0;
				deb_n    = '0;
				frz_n    = 1'b0;
				hold_n   = '0;
				rflags_n = '0;
			end
			if (!item.cpu_write && (item.roml_sel || item.romh_sel)) begin
				drive = 1'b1;
				off   = {item.bus_addr, item.romh_sel};
			end else if (!item.cpu_write && (item.io1_sel || item.io2_sel)) begin
				drive = 1'b1;
				off   = {item.io1_sel ? IO1_PAGE : IO2_PAGE, item.bus_addr[7:0], 1'b0};
			end else begin
				if (item.cpu_write) begin
					if (wrun_n != COUNT_SAT) begin
						wrun_n = wrun_n + 8'd1;
					end
				end else begin
					wrun_n = '0;
				end
				if (item.cpu_write && item.io2_sel && active_n
						&& item.bus_addr[7:0] == CTRL_REG_LOW) begin
					line_n   = item.data_in[6:4];
					bank_n   = item.data_in[BANK_W-1:0] & mask;
					active_n = ~item.data_in[7];
				end else if (item.freeze_button && deb_n == '0) begin
					deb_n     = cfg.debounce_cycles;
					frz_n     = 1'b1;
					wrun_n    = '0;
					line_n[2] = 1'b0;
				end else begin
					if (deb_n != '0) begin
						deb_n = deb_n - 20'd1;
					end
					// Three writes in a row after a freeze press switch to ultimax.
					if (frz_n && wrun_n == FREEZE_RUN) begin
						line_n = {line_n[2], 2'b01};
						frz_n  = 1'b0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b1;
			bank_q   <= '0;
			line_q   <= '0;
			wrun_q   <= '0;
			deb_q    <= '0;
			frz_q    <= 1'b0;
			hold_q   <= '0;
			rflags_q <= '0;
		end else if (en) begin
			active_q <= active_n;
			bank_q   <= bank_n;
			line_q   <= line_n;
			wrun_q   <= wrun_n;
			deb_q    <= deb_n;
			frz_q    <= frz_n;
			hold_q   <= hold_n;
			rflags_q <= rflags_n;
		end
	end

	assign rom.we    = en && item.req_type;
	assign rom.waddr = item.rom_index;
	assign rom.wdata = item.data_in;
	assign rom.re    = en && !item.req_type && drive;
	assign rom.raddr = {bank_n, off};

	assign view.exrom  = line_n[0];
	assign view.game   = line_n[1];
	assign view.nmi    = line_n[2];
	assign view.active = active_n;
	assign view.bank   = bank_n;

	a_freeze_pulls_nmi: assert property (@(posedge clk) disable iff (!arst_n)
		en && frz_n && !frz_q |=> !line_q[2] && frz_q)
		else $error("freeze press did not pull NMI low");

	a_quiet_steps: assert property (@(posedge clk) disable iff (!arst_n)
		en && (item.req_type || item.vic_access)
		|=> $stable(bank_q) && $stable(line_q) && $stable(active_q) && $stable(wrun_q))
		else $error("load or video access changed the control state");

	a_hold_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(bank_q) && $stable(line_q) && $stable(deb_q) && $stable(hold_q))
		else $error("control state moved without a request");

endmodule

// ----- src/freezer_cartridge_bank_logic.sv -----
// Top level of the freezer cartridge bank logic: request and result pipeline.
// Depends on fcb_pkg, fcb_in_if, fcb_out_if, fcb_cfg, fcb_ctrl and fcb_rom.
//
// One request (a bus half-cycle or a ROM image byte load) is taken every clock
// cycle while the sink does not stall, and its result is offered from the second
// stage: the first stage registers the request, decodes it against the control
// state and issues the ROM image read, and the second holds the registered read
// byte with the new line levels. The rate of one request per cycle is set by the
// state update and the one read and one write port of the 256 KiB image store.
// Results wait in the second stage while the sink stalls, and a new request is
// still taken then if the first stage is free. The image store has no reset;
// reading a byte that was never loaded returns an undefined value.
module freezer_cartridge_bank_logic import fcb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	fcb_in_if.sink                item,
	fcb_out_if.source             result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t      cfg;
	rom_port_t rom;
	ctl_view_t view;
	logic      drive;
	logic      adv;
	logic      step;
	logic      valid_s1;
	in_item_t  item_s1;
	logic      valid_s2;
	logic      drive_s2;
	ctl_view_t view_s2;
	logic [7:0] rd_data_s2;

	assign adv        = !valid_s2 || result.ready;
	assign step       = valid_s1 && adv;
	assign item.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (item.ready) begin
				valid_s1 <= item.valid;
			end
			if (adv) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1 <= item.data;
		end
		if (step) begin
			drive_s2 <= drive;
			view_s2  <= view;
		end
	end

	fcb_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.wdata  (cfg_data),
		.cfg    (cfg)
	);

	fcb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (step),
		.item   (item_s1),
		.cfg    (cfg),
		.rom    (rom),
		.drive  (drive),
		.view   (view)
	);

	fcb_rom u_rom (
		.clk        (clk),
		.rom        (rom),
		.rd_data_s2 (rd_data_s2)
	);

	assign result.valid            = valid_s2;
	assign result.data.drive_data  = drive_s2;
	assign result.data.data_out    = drive_s2 ? rd_data_s2 : 8'h00;
	assign result.data.exrom_ctl   = view_s2.exrom;
	assign result.data.game_ctl    = view_s2.game;
	assign result.data.nmi_ctl     = view_s2.nmi;
	assign result.data.cart_active = view_s2.active;
	assign result.data.bank_now    = view_s2.bank;

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |=> valid_s1)
		else $error("accepted request lost before the first stage");

	a_stall_holds_s2: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !result.ready |=> valid_s2 && $stable(drive_s2) && $stable(view_s2))
		else $error("stalled result changed in the second stage");

	a_no_step_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !result.ready |-> !step && !rom.we && !rom.re)
		else $error("first stage advanced into a stalled second stage");

endmodule

// ----- tb/sv/tb_freezer_cartridge_bank_logic.sv -----
// Self-checking testbench of freezer_cartridge_bank_logic: directed and random bus
// half-cycles and image loads, a shadow of the cartridge state, checks on every result.
// Depends on fcb_pkg, fcb_in_if, fcb_out_if and the block itself.
module tb_freezer_cartridge_bank_logic;
	import fcb_pkg::*;

	typedef struct {
		in_item_t  item;
		out_item_t outcome;
	} bus_request_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  req_valid = 1'b0;
	in_item_t              req_item = '0;
	logic                  res_ready = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	fcb_in_if  req_if ();
	fcb_out_if res_if ();

	assign req_if.valid = req_valid;
	assign req_if.data  = req_item;
	assign res_if.ready = res_ready;

	freezer_cartridge_bank_logic u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (req_if),
		.result    (res_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	bus_request_t pending_requests[$];
	out_item_t    bus_results_due[$];
	int           issued = 0;
	int           mismatches = 0;

	// Shadow of the cartridge state and of its registers.
	bit [7:0]    image_mem [IMG_DEPTH];
	bit          image_written [IMG_DEPTH];
	logic        sh_active;
	logic [3:0]  sh_bank;
	logic [2:0]  sh_lines;
	logic [7:0]  sh_write_run;
	logic [19:0] sh_debounce;
	logic        sh_freeze_pending;
	logic [7:0]  sh_reset_hold;
	logic [1:0]  sh_reset_flags;
	logic [4:0]  sh_bank_count;
	logic [19:0] sh_debounce_cycles;
	logic [7:0]  sh_hold_min;

	function automatic void clear_cartridge_state();
		sh_active = 1'b1;
		sh_bank = '0;
		sh_lines = '0;
		sh_write_run = '0;
		sh_debounce = '0;
		sh_freeze_pending = 1'b0;
		sh_reset_hold = '0;
		sh_reset_flags = '0;
	endfunction

	function automatic logic [7:0] bank_byte(logic [13:0] off);
		return image_mem[{sh_bank, off}];
	endfunction

	function automatic out_item_t predict_bus_result(in_item_t it);
		out_item_t  r;
		logic [4:0] count_less;
		r = '0;
		if (it.req_type) begin
			image_mem[it.rom_index] = it.data_in;
			image_written[it.rom_index] = 1'b1;
		end else if (it.vic_access) begin
			if (it.romh_sel) begin
				r.drive_data = 1'b1;
				r.data_out = bank_byte({it.bus_addr, 1'b1});
			end
		end else begin
			if (it.reset_low) begin
				if (sh_reset_hold != COUNT_SAT)
					sh_reset_hold++;
				sh_reset_flags = 2'b01;
			end else begin
				sh_reset_flags = sh_reset_flags[0] ? 2'b10 : (sh_reset_flags & 2'b10);
			end
			if (sh_reset_hold > sh_hold_min && sh_reset_flags[1])
				clear_cartridge_state();

			if (!it.cpu_write && (it.roml_sel || it.romh_sel)) begin
				r.drive_data = 1'b1;
				r.data_out = bank_byte({it.bus_addr, it.romh_sel});
			end else if (!it.cpu_write && (it.io1_sel || it.io2_sel)) begin
				r.drive_data = 1'b1;
				r.data_out = bank_byte({it.io1_sel ? IO1_PAGE : IO2_PAGE, it.bus_addr[7:0], 1'b0});
			end else begin
				if (it.cpu_write) begin
					if (sh_write_run != COUNT_SAT)
						sh_write_run++;
				end else begin
					sh_write_run = '0;
				end
				if (it.cpu_write && it.io2_sel && sh_active && it.bus_addr[7:0] == CTRL_REG_LOW) begin
					count_less = sh_bank_count - 5'd1;
					sh_lines = it.data_in[6:4];
					sh_bank = it.data_in[3:0] & count_less[3:0];
					sh_active = ~it.data_in[7];
				end else if (it.freeze_button && sh_debounce == 0) begin
					sh_debounce = sh_debounce_cycles;
					sh_freeze_pending = 1'b1;
					sh_write_run = '0;
					sh_lines[2] = 1'b0;
				end else begin
					if (sh_debounce > 0)
						sh_debounce--;
					if (sh_freeze_pending && sh_write_run == FREEZE_RUN) begin
						sh_lines = {sh_lines[2], 2'b01};
						sh_freeze_pending = 1'b0;
					end
				end
			end
		end
		r.exrom_ctl = sh_lines[0];
		r.game_ctl = sh_lines[1];
		r.nmi_ctl = sh_lines[2];
		r.cart_active = sh_active;
		r.bank_now = sh_bank;
		return r;
	endfunction

	function automatic in_item_t random_fields();
		bit [63:0] raw;
		raw = {$urandom, $urandom};
		return raw[$bits(in_item_t)-1:0];
	endfunction

	function automatic in_item_t bus_base();
		in_item_t it;
		it = random_fields();
		it.req_type = 1'b0;
		it.vic_access = 1'b0;
		it.reset_low = ($urandom_range(0, 15) == 0);
		it.freeze_button = ($urandom_range(0, 7) == 0);
		return it;
	endfunction

	// A read of the image is only issued once its byte has been loaded, in the current
	// bank and in bank zero, since a long reset may switch banks within the half-cycle.
	task automatic enqueue_request(in_item_t it);
		logic [13:0]  off;
		bit           reads;
		in_item_t     fill;
		bus_request_t entry;
		reads = 1'b0;
		off = '0;
		if (!it.req_type) begin
			if (it.vic_access) begin
				reads = it.romh_sel;
				off = {it.bus_addr, 1'b1};
			end else if (!it.cpu_write && (it.roml_sel || it.romh_sel)) begin
				reads = 1'b1;
				off = {it.bus_addr, it.romh_sel};
			end else if (!it.cpu_write && (it.io1_sel || it.io2_sel)) begin
				reads = 1'b1;
				off = {it.io1_sel ? IO1_PAGE : IO2_PAGE, it.bus_addr[7:0], 1'b0};
			end
		end
		if (reads && !image_written[{sh_bank, off}]) begin
			fill = random_fields();
			fill.req_type = 1'b1;
			fill.rom_index = {sh_bank, off};
			enqueue_request(fill);
		end
		if (reads && !image_written[{4'd0, off}]) begin
			fill = random_fields();
			fill.req_type = 1'b1;
			fill.rom_index = {4'd0, off};
			enqueue_request(fill);
		end
		entry.item = it;
		entry.outcome = predict_bus_result(it);
		pending_requests.push_back(entry);
		issued++;
	endtask

	task automatic apply_settings(logic [4:0] count, logic [19:0] debounce, logic [7:0] hold_min);
		while (pending_requests.size() != 0 || bus_results_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_BANK_COUNT;
		cfg_data <= CFG_DATA_W'(count);
		@(posedge clk);
		cfg_index <= CFG_DEBOUNCE;
		cfg_data <= debounce;
		@(posedge clk);
		cfg_index <= CFG_RESET_HOLD;
		cfg_data <= CFG_DATA_W'(hold_min);
		@(posedge clk);
		cfg_we <= 1'b0;
		sh_bank_count = count;
		sh_debounce_cycles = debounce;
		sh_hold_min = hold_min;
	endtask

	task automatic random_traffic(int quota);
		int       stop_at;
		int       kind;
		int       n;
		in_item_t it;
		stop_at = issued + quota;
		while (issued < stop_at) begin
			kind = $urandom_range(0, 99);
			if (kind < 30) begin
				it = bus_base();
				it.cpu_write = 1'b0;
				it.vic_access = ($urandom_range(0, 3) == 0);
				enqueue_request(it);
			end else if (kind < 40) begin
				it = bus_base();
				it.cpu_write = 1'b1;
				it.io2_sel = 1'b1;
				it.bus_addr[7:0] = CTRL_REG_LOW;
				it.data_in[7] = ($urandom_range(0, 7) == 0);
				enqueue_request(it);
			end else if (kind < 52) begin
				it = bus_base();
				it.freeze_button = 1'b1;
				it.reset_low = 1'b0;
				it.cpu_write = 1'($urandom_range(0, 1));
				it.io2_sel = 1'b0;
				if (!it.cpu_write) begin
					it.roml_sel = 1'b0;
					it.romh_sel = 1'b0;
					it.io1_sel = 1'b0;
				end
				enqueue_request(it);
				repeat (3) begin
					it = bus_base();
					it.cpu_write = 1'b1;
					it.io2_sel = 1'b0;
					it.reset_low = 1'b0;
					it.freeze_button = ($urandom_range(0, 3) == 0);
					enqueue_request(it);
				end
			end else if (kind < 57) begin
				n = (sh_hold_min == COUNT_SAT) ? $urandom_range(1, 8)
				                              : sh_hold_min + 1 + $urandom_range(0, 3);
				repeat (n) begin
					it = bus_base();
					it.reset_low = 1'b1;
					enqueue_request(it);
				end
				it = bus_base();
				it.reset_low = 1'b0;
				enqueue_request(it);
			end else if (kind < 67) begin
				it = bus_base();
				it.cpu_write = 1'b1;
				enqueue_request(it);
			end else if (kind < 75) begin
				it = random_fields();
				it.req_type = 1'b1;
				enqueue_request(it);
			end else begin
				enqueue_request(random_fields());
			end
		end
	endtask

	// Sender: bursts of random length separated by random gaps.
	int burst_left = 1;
	int gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			if (req_valid && req_if.ready) begin
				bus_results_due.push_back(pending_requests[0].outcome);
				void'(pending_requests.pop_front());
			end
			if (!req_valid || req_if.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					req_valid <= 1'b0;
				end else if (pending_requests.size() > 0) begin
					req_valid <= 1'b1;
					req_item <= pending_requests[0].item;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 16);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	task automatic compare_field(string field, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0h actual %0h", $time, field, want, got);
			mismatches++;
		end
	endtask

	// Receiver: ready follows a rotating stall pattern that is changed now and then.
	logic [7:0] stall_pattern = 8'hFF;
	int         pattern_age = 0;
	out_item_t  due_result;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else begin
			if (res_if.valid && res_ready) begin
				if (bus_results_due.size() == 0) begin
					$display("%0t: no result expected, actual %p", $time, res_if.data);
					mismatches++;
				end else begin
					due_result = bus_results_due.pop_front();
					compare_field("drive_data", due_result.drive_data, res_if.data.drive_data);
					compare_field("data_out", due_result.data_out, res_if.data.data_out);
					compare_field("exrom_ctl", due_result.exrom_ctl, res_if.data.exrom_ctl);
					compare_field("game_ctl", due_result.game_ctl, res_if.data.game_ctl);
					compare_field("nmi_ctl", due_result.nmi_ctl, res_if.data.nmi_ctl);
					compare_field("cart_active", due_result.cart_active, res_if.data.cart_active);
					compare_field("bank_now", due_result.bank_now, res_if.data.bank_now);
				end
			end
			res_ready <= stall_pattern[0];
			stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
			pattern_age++;
			if (pattern_age == 40) begin
				pattern_age = 0;
				stall_pattern = ($urandom_range(0, 2) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
			end
		end
	end

	initial begin
		#8000000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		in_item_t it;
		clear_cartridge_state();
		sh_bank_count = BANK_COUNT_RST;
		sh_debounce_cycles = DEBOUNCE_RST;
		sh_hold_min = HOLD_MIN_RST;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		apply_settings(5'd16, 20'd0, 8'd2);
		it = '0;
		it.req_type = 1'b1;
		it.data_in = 8'hFF;
		enqueue_request(it);
		it.rom_index = '1;
		it.data_in = 8'h00;
		enqueue_request(it);
		it = '0;
		it.cpu_write = 1'b1;
		it.io2_sel = 1'b1;
		it.bus_addr = '1;
		it.data_in = 8'h0F;
		enqueue_request(it);
		it = '0;
		it.vic_access = 1'b1;
		it.romh_sel = 1'b1;
		it.bus_addr = '1;
		enqueue_request(it);
		it.romh_sel = 1'b0;
		it.roml_sel = 1'b1;
		enqueue_request(it);
		it = '0;
		it.roml_sel = 1'b1;
		enqueue_request(it);
		it.romh_sel = 1'b1;
		enqueue_request(it);
		it = '0;
		it.io1_sel = 1'b1;
		it.bus_addr = 13'h00FF;
		enqueue_request(it);
		it.io2_sel = 1'b1;
		enqueue_request(it);
		it.io1_sel = 1'b0;
		it.bus_addr = '0;
		enqueue_request(it);
		it = '0;
		it.cpu_write = 1'b1;
		it.io2_sel = 1'b1;
		it.bus_addr = 13'h00FF;
		it.data_in = 8'h70;
		enqueue_request(it);
		// A freeze press followed by three writes ends in ultimax.
		it = '0;
		it.freeze_button = 1'b1;
		enqueue_request(it);
		it = '0;
		it.cpu_write = 1'b1;
		it.bus_addr = 13'h1234;
		repeat (3) enqueue_request(it);
		// Disabling hides the control register until a long reset.
		it = '0;
		it.cpu_write = 1'b1;
		it.io2_sel = 1'b1;
		it.bus_addr = 13'h1FFF;
		it.data_in = 8'h80;
		enqueue_request(it);
		it.data_in = 8'h3F;
		enqueue_request(it);
		it = '0;
		it.reset_low = 1'b1;
		repeat (3) enqueue_request(it);
		it.reset_low = 1'b0;
		enqueue_request(it);
		random_traffic(230);

		apply_settings(5'd1, 20'hFFFFF, 8'd255);
		random_traffic(200);
		apply_settings(5'd0, 20'd3, 8'd0);
		random_traffic(200);
		apply_settings(5'd5, 20'd20, 8'd31);
		random_traffic(200);
		apply_settings(5'd8, 20'($urandom_range(0, 40)), 8'($urandom_range(0, 60)));
		random_traffic(200);
		apply_settings(5'd2, 20'd1, 8'd7);
		random_traffic(200);

		while (pending_requests.size() != 0 || bus_results_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
